[rtl/inc_pkg.sv]
// Package for the inverse normal CDF unit: widths, request side-band type and
// fixed-point constants (Q.32 coefficients, 2 ln 2). No dependencies.
package inc_pkg;

    localparam int PROB_W      = 32;
    localparam int QOUT_W      = 32;
    localparam int OUT_SHIFT   = 4;
    localparam int M_W         = 33;
    localparam int E_W         = 5;
    localparam int Y_W         = 38;
    localparam int K_W         = 34;
    localparam int T_W         = 36;
    localparam int R_W         = 71;
    localparam int N_W         = 38;
    localparam int QD_W        = 35;
    localparam int SQ_STAGES   = 32;
    localparam int RT_STAGES   = T_W;
    localparam int DV_STAGES   = QD_W;

    typedef struct packed {
        logic invalid;
        logic neg;
    } side_t;

    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
    localparam logic [K_W-1:0] TWO_LN2_Q32 = K_W'(((LN2_Q64 >> 30) + 64'd1) >> 1);

    localparam logic [N_W-1:0] ONE_Q32 = N_W'(64'd1 << 32);
    localparam logic [N_W-1:0] NUM_C0 = N_W'(((64'd2515517 << 32) + 64'd500000) / 64'd1000000);
    localparam logic [N_W-1:0] NUM_C1 = N_W'(((64'd802853 << 32) + 64'd500000) / 64'd1000000);
    localparam logic [N_W-1:0] NUM_C2 = N_W'(((64'd10328 << 32) + 64'd500000) / 64'd1000000);
    localparam logic [N_W-1:0] DEN_D1 = N_W'(((64'd1432788 << 32) + 64'd500000) / 64'd1000000);
    localparam logic [N_W-1:0] DEN_D2 = N_W'(((64'd189269 << 32) + 64'd500000) / 64'd1000000);
    localparam logic [N_W-1:0] DEN_D3 = N_W'(((64'd1308 << 32) + 64'd500000) / 64'd1000000);

endpackage

[rtl/inc_log2.sv]
// Front end: folds p to q, normalises, log2 by 32 squaring stages, scales to -2 ln q.
// Depends on inc_pkg.
module inc_log2
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [inc_pkg::PROB_W-1:0] prob,
    output logic                       out_vld,
    output inc_pkg::side_t             out_side,
    output logic [inc_pkg::Y_W-1:0]    u
);

    localparam int S = inc_pkg::SQ_STAGES;

    logic                        a_vld_reg;
    inc_pkg::side_t              a_side_reg;
    logic [inc_pkg::PROB_W-1:0]  a_q_reg;
    logic                        b_vld_reg;
    inc_pkg::side_t              b_side_reg;
    logic [inc_pkg::M_W-1:0]     b_m_reg;
    logic [inc_pkg::E_W-1:0]     b_e_reg;

    logic                        s_vld_reg  [S];
    inc_pkg::side_t              s_side_reg [S];
    logic [inc_pkg::M_W-1:0]     s_m_reg    [S];
    logic [inc_pkg::E_W-1:0]     s_e_reg    [S];
    logic [31:0]                 s_f_reg    [S];

    logic                        u_vld_reg;
    inc_pkg::side_t              u_side_reg;
    logic [inc_pkg::Y_W-1:0]     u_reg;

    inc_pkg::side_t              a_side_next;
    logic [inc_pkg::PROB_W-1:0]  a_q_next;
    logic [inc_pkg::E_W-1:0]     b_e_next;
    logic [inc_pkg::M_W-1:0]     b_m_next;
    logic [inc_pkg::M_W-1:0]     m_cur  [S];
    logic [31:0]                 f_cur  [S];
    logic [2*inc_pkg::M_W-1:0]   sq     [S];
    logic [inc_pkg::M_W:0]       sr     [S];
    logic [inc_pkg::M_W-1:0]     s_m_next [S];
    logic [31:0]                 s_f_next [S];
    logic [inc_pkg::Y_W-1:0]     y;
    logic [inc_pkg::Y_W+inc_pkg::K_W-1:0] yp;

    always_comb
    begin
        a_side_next.invalid = (prob == '0);
        a_side_next.neg     = ~prob[inc_pkg::PROB_W-1];
        if (a_side_next.invalid)
        begin
            a_q_next = inc_pkg::PROB_W'(1);
        end
        else if (a_side_next.neg)
        begin
            a_q_next = prob;
        end
        else
        begin
            a_q_next = inc_pkg::PROB_W'((33'h1 << inc_pkg::PROB_W) - {1'b0, prob});
        end
    end

    always_comb
    begin
        b_e_next = '0;
        for (int i = 0; i < inc_pkg::PROB_W; i++)
        begin
            if (a_q_reg[i])
            begin
                b_e_next = inc_pkg::E_W'(i);
            end
        end
        b_m_next = {1'b0, a_q_reg} << (6'd32 - {1'b0, b_e_next});
    end

    always_comb
    begin
        for (int k = 0; k < S; k++)
        begin
            m_cur[k] = (k == 0) ? b_m_reg : s_m_reg[(k == 0) ? 0 : k - 1];
            f_cur[k] = (k == 0) ? 32'd0   : s_f_reg[(k == 0) ? 0 : k - 1];
            sq[k]    = m_cur[k] * m_cur[k];
            sr[k]    = sq[k][2*inc_pkg::M_W-1:32] + (inc_pkg::M_W+1)'(sq[k][31]);
            s_f_next[k] = f_cur[k];
            if (sr[k][inc_pkg::M_W])
            begin
                s_m_next[k] = sr[k][inc_pkg::M_W:1];
                s_f_next[k][31-k] = 1'b1;
            end
            else
            begin
                s_m_next[k] = sr[k][inc_pkg::M_W-1:0];
            end
        end
        y  = {6'd32 - {1'b0, s_e_reg[S-1]}, 32'd0} - {6'd0, s_f_reg[S-1]};
        yp = y * inc_pkg::TWO_LN2_Q32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            u_vld_reg <= 1'b0;
            for (int k = 0; k < S; k++)
            begin
                s_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            s_vld_reg[0] <= b_vld_reg;
            for (int k = 1; k < S; k++)
            begin
                s_vld_reg[k] <= s_vld_reg[k-1];
            end
            u_vld_reg <= s_vld_reg[S-1];
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        a_q_reg    <= a_q_next;
        b_side_reg <= a_side_reg;
        b_m_reg    <= b_m_next;
        b_e_reg    <= b_e_next;
        s_side_reg[0] <= b_side_reg;
        s_e_reg[0]    <= b_e_reg;
        for (int k = 1; k < S; k++)
        begin
            s_side_reg[k] <= s_side_reg[k-1];
            s_e_reg[k]    <= s_e_reg[k-1];
        end
        for (int k = 0; k < S; k++)
        begin
            s_m_reg[k] <= s_m_next[k];
            s_f_reg[k] <= s_f_next[k];
        end
        u_side_reg <= s_side_reg[S-1];
        u_reg      <= yp[inc_pkg::Y_W+31:32] + inc_pkg::Y_W'(yp[31]);
    end

    assign out_vld  = u_vld_reg;
    assign out_side = u_side_reg;
    assign u        = u_reg;

endmodule

[rtl/inc_sqrt.sv]
// Digit-by-digit square root, one result bit per stage: t = sqrt(-2 ln q) in Q.32.
// Depends on inc_pkg.
module inc_sqrt
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  inc_pkg::side_t          in_side,
    input  logic [inc_pkg::Y_W-1:0] u,
    output logic                    out_vld,
    output inc_pkg::side_t          out_side,
    output logic [inc_pkg::T_W-1:0] t
);

    localparam int S = inc_pkg::RT_STAGES;

    logic                    vld_reg  [S];
    inc_pkg::side_t          side_reg [S];
    logic [inc_pkg::R_W-1:0] rem_reg  [S];
    logic [inc_pkg::T_W-1:0] root_reg [S];

    logic [inc_pkg::R_W-1:0] rem_cur   [S];
    logic [inc_pkg::T_W-1:0] root_cur  [S];
    logic [inc_pkg::R_W-1:0] trial     [S];
    logic [inc_pkg::R_W-1:0] rem_next  [S];
    logic [inc_pkg::T_W-1:0] root_next [S];

    // rounded square <= u  <=>  c*c <= u*2^32 + 2^31 - 1
    always_comb
    begin
        for (int k = 0; k < S; k++)
        begin
            if (k == 0)
            begin
                rem_cur[k]  = {1'b0, u, 32'h7FFF_FFFF};
                root_cur[k] = '0;
            end
            else
            begin
                rem_cur[k]  = rem_reg[(k == 0) ? 0 : k - 1];
                root_cur[k] = root_reg[(k == 0) ? 0 : k - 1];
            end
            trial[k] = (inc_pkg::R_W'(root_cur[k]) << (S - k))
                     + (inc_pkg::R_W'(1) << (2 * (S - 1 - k)));
            rem_next[k]  = rem_cur[k];
            root_next[k] = root_cur[k];
            if (trial[k] <= rem_cur[k])
            begin
                rem_next[k] = rem_cur[k] - trial[k];
                root_next[k][S-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < S; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < S; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < S; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < S; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_vld  = vld_reg[S-1];
    assign out_side = side_reg[S-1];
    assign t        = root_reg[S-1];

endmodule

[rtl/inc_poly.sv]
// Horner evaluation of numerator and denominator polynomials in t, three stages.
// Depends on inc_pkg.
module inc_poly
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  inc_pkg::side_t          in_side,
    input  logic [inc_pkg::T_W-1:0] t_in,
    output logic                    out_vld,
    output inc_pkg::side_t          out_side,
    output logic [inc_pkg::T_W-1:0] t_out,
    output logic [inc_pkg::N_W-1:0] num,
    output logic [inc_pkg::N_W-1:0] den
);

    localparam int NW = inc_pkg::N_W;

    function automatic logic [NW-1:0] qrnd(input logic [2*NW-1:0] p);
        return p[NW+31:32] + NW'(p[31]);
    endfunction

    logic                    vld_reg  [3];
    inc_pkg::side_t          side_reg [3];
    logic [inc_pkg::T_W-1:0] t_reg    [3];
    logic [NW-1:0]           a1_reg, b1_reg, a2_reg, b2_reg, num_reg, den_reg;

    logic [NW-1:0]   t_ext0, t_ext1, t_ext2;
    logic [2*NW-1:0] pa1, pb1, pa2, pb2, pb3;

    always_comb
    begin
        t_ext0 = NW'(t_in);
        t_ext1 = NW'(t_reg[0]);
        t_ext2 = NW'(t_reg[1]);
        pa1 = inc_pkg::NUM_C2 * t_ext0;
        pb1 = inc_pkg::DEN_D3 * t_ext0;
        pa2 = (a1_reg + inc_pkg::NUM_C1) * t_ext1;
        pb2 = (b1_reg + inc_pkg::DEN_D2) * t_ext1;
        pb3 = (b2_reg + inc_pkg::DEN_D1) * t_ext2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        side_reg[1] <= side_reg[0];
        side_reg[2] <= side_reg[1];
        t_reg[0]    <= t_in;
        t_reg[1]    <= t_reg[0];
        t_reg[2]    <= t_reg[1];
        a1_reg      <= qrnd(pa1);
        b1_reg      <= qrnd(pb1);
        a2_reg      <= qrnd(pa2);
        b2_reg      <= qrnd(pb2);
        num_reg     <= a2_reg + inc_pkg::NUM_C0;
        den_reg     <= qrnd(pb3) + inc_pkg::ONE_Q32;
    end

    assign out_vld  = vld_reg[2];
    assign out_side = side_reg[2];
    assign t_out    = t_reg[2];
    assign num      = num_reg;
    assign den      = den_reg;

endmodule

[rtl/inc_div.sv]
// Restoring divider, one quotient bit per stage: floor(num * 2^33 / den).
// Depends on inc_pkg.
module inc_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  inc_pkg::side_t           in_side,
    input  logic [inc_pkg::T_W-1:0]  t_in,
    input  logic [inc_pkg::N_W-1:0]  num,
    input  logic [inc_pkg::N_W-1:0]  den,
    output logic                     out_vld,
    output inc_pkg::side_t           out_side,
    output logic [inc_pkg::T_W-1:0]  t_out,
    output logic [inc_pkg::QD_W-1:0] quot
);

    localparam int S  = inc_pkg::DV_STAGES;
    localparam int NW = inc_pkg::N_W;

    logic                     vld_reg  [S];
    inc_pkg::side_t           side_reg [S];
    logic [inc_pkg::T_W-1:0]  t_reg    [S];
    logic [NW-1:0]            den_reg  [S];
    logic [NW-1:0]            rem_reg  [S];
    logic [inc_pkg::QD_W-1:0] q_reg    [S];
    logic                     lsb_reg;

    logic [NW-1:0]            rem_cur [S];
    logic [NW-1:0]            den_cur [S];
    logic [inc_pkg::QD_W-1:0] q_cur   [S];
    logic                     nbit    [S];
    logic [NW:0]              sh      [S];
    logic [NW-1:0]            rem_next [S];
    logic [inc_pkg::QD_W-1:0] q_next   [S];

    always_comb
    begin
        for (int k = 0; k < S; k++)
        begin
            if (k == 0)
            begin
                rem_cur[k] = num >> 2;
                den_cur[k] = den;
                q_cur[k]   = '0;
                nbit[k]    = num[1];
            end
            else
            begin
                rem_cur[k] = rem_reg[(k == 0) ? 0 : k - 1];
                den_cur[k] = den_reg[(k == 0) ? 0 : k - 1];
                q_cur[k]   = q_reg[(k == 0) ? 0 : k - 1];
                nbit[k]    = (k == 1) ? lsb_reg : 1'b0;
            end
            sh[k]       = {rem_cur[k], nbit[k]};
            rem_next[k] = sh[k][NW-1:0];
            q_next[k]   = q_cur[k];
            if (sh[k] >= {1'b0, den_cur[k]})
            begin
                rem_next[k] = NW'(sh[k] - {1'b0, den_cur[k]});
                q_next[k][S-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < S; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < S; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lsb_reg     <= num[0];
        side_reg[0] <= in_side;
        t_reg[0]    <= t_in;
        for (int k = 1; k < S; k++)
        begin
            side_reg[k] <= side_reg[k-1];
            t_reg[k]    <= t_reg[k-1];
        end
        for (int k = 0; k < S; k++)
        begin
            den_reg[k] <= den_cur[k];
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
        end
    end

    assign out_vld  = vld_reg[S-1];
    assign out_side = side_reg[S-1];
    assign t_out    = t_reg[S-1];
    assign quot     = q_reg[S-1];

endmodule

[rtl/inverse_normal_cdf_unit.sv]
// Top level of the inverse normal CDF unit: log2, square root, polynomial and
// divider pipelines, then sign, rounding and saturation. Depends on inc_pkg.
//
// Usage:
//   Raise start with a probability on prob_in (unsigned Q0.32). The request is
//   taken at any rising edge with start high; busy is always low, so a new
//   request may be issued in every cycle.
//   Each request yields one result: done is high for one cycle with
//   quantile_out (signed Q4.28) and invalid. The stage counts are 35 for
//   log2 (32 squaring stages), 36 for the square root, 3 for the
//   polynomials, 35 for the divider and one output stage.
//   Throughput is one request per cycle.
//   A probability of zero returns invalid high and a zero quantile.
//   Results beyond the output range saturate.
//   Reset clears all valid bits, so no done strobe follows reset until a
//   request is made. The receiver cannot stall; each result is presented
//   once and must be taken in that cycle.
module inverse_normal_cdf_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [inc_pkg::PROB_W-1:0]        prob_in,
    output logic                              done,
    output logic signed [inc_pkg::QOUT_W-1:0] quantile_out,
    output logic                              invalid
);

    logic                     l_vld, s_vld, p_vld, d_vld;
    inc_pkg::side_t           l_side, s_side, p_side, d_side;
    logic [inc_pkg::Y_W-1:0]  l_u;
    logic [inc_pkg::T_W-1:0]  s_t, p_t, d_t;
    logic [inc_pkg::N_W-1:0]  p_num, p_den;
    logic [inc_pkg::QD_W-1:0] d_quot;

    logic                      done_reg;
    logic [inc_pkg::QOUT_W-1:0] quant_reg;
    logic                      inv_reg;

    logic [inc_pkg::QD_W:0]    r_sum;
    logic [inc_pkg::N_W-1:0]   x;
    logic                      xneg, oneg;
    logic [inc_pkg::N_W-1:0]   mag;
    logic [inc_pkg::N_W-1:0]   rsum;
    logic [inc_pkg::N_W-inc_pkg::OUT_SHIFT-1:0] rmag, lim, smag;
    logic [inc_pkg::QOUT_W-1:0] quant_next;

    assign busy = 1'b0;

    inc_log2 u_log2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start),
        .prob     (prob_in),
        .out_vld  (l_vld),
        .out_side (l_side),
        .u        (l_u)
    );

    inc_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (l_vld),
        .in_side  (l_side),
        .u        (l_u),
        .out_vld  (s_vld),
        .out_side (s_side),
        .t        (s_t)
    );

    inc_poly u_poly
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_vld),
        .in_side  (s_side),
        .t_in     (s_t),
        .out_vld  (p_vld),
        .out_side (p_side),
        .t_out    (p_t),
        .num      (p_num),
        .den      (p_den)
    );

    inc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p_vld),
        .in_side  (p_side),
        .t_in     (p_t),
        .num      (p_num),
        .den      (p_den),
        .out_vld  (d_vld),
        .out_side (d_side),
        .t_out    (d_t),
        .quot     (d_quot)
    );

    // quotient rounded half up to Q.32, then x = t - r, sign-magnitude rounding
    always_comb
    begin
        r_sum = {1'b0, d_quot} + (inc_pkg::QD_W+1)'(1);
        x     = {2'b00, d_t} - {3'b000, r_sum[inc_pkg::QD_W:1]};
        xneg  = x[inc_pkg::N_W-1];
        oneg  = xneg ^ d_side.neg;
        mag   = xneg ? (~x + inc_pkg::N_W'(1)) : x;
        rsum  = mag + inc_pkg::N_W'(1 << (inc_pkg::OUT_SHIFT - 1));
        rmag  = rsum[inc_pkg::N_W-1:inc_pkg::OUT_SHIFT];
        lim   = oneg ? (inc_pkg::N_W-inc_pkg::OUT_SHIFT)'(34'h0_8000_0000)
                     : (inc_pkg::N_W-inc_pkg::OUT_SHIFT)'(34'h0_7FFF_FFFF);
        smag  = (rmag > lim) ? lim : rmag;
        if (d_side.invalid)
        begin
            quant_next = '0;
        end
        else if (oneg)
        begin
            quant_next = ~smag[inc_pkg::QOUT_W-1:0] + inc_pkg::QOUT_W'(1);
        end
        else
        begin
            quant_next = smag[inc_pkg::QOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        quant_reg <= quant_next;
        inv_reg   <= d_side.invalid;
    end

    assign done         = done_reg;
    assign quantile_out = $signed(quant_reg);
    assign invalid      = inv_reg;

endmodule
